### design/glid_pkg.sv
// shared types and constants for the gif lzw interlace decoder
`default_nettype none
package glid_pkg;
  localparam int TableDepth = 4096;
  localparam int CodeBits   = 12;
  localparam int StackDepth = TableDepth + 1;
  localparam int StackAw    = 13;

  typedef enum logic [2:0] {
    ST_TAKEN   = 3'd0,
    ST_REFUSED = 3'd1,
    ST_PIXEL   = 3'd2,
    ST_NEED    = 3'd3,
    ST_DONE    = 3'd4,
    ST_ABORT   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CFG_MIN   = 3'd0,
    CFG_MASK  = 3'd1,
    CFG_WIDTH = 3'd2,
    CFG_HEIGHT = 3'd3,
    CFG_ILACE = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_CHECK, S_FETCH, S_CLASSIFY, S_WALK_RD, S_WALK,
    S_WRITE, S_POP_RD, S_POP, S_RESULT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic push;
    logic check;
    logic fetch;
    logic classify;
    logic walk_rd;
    logic walk;
    logic write;
    logic pop_rd;
    logic pop;
    logic set_result;
    status_e result;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic room;
    logic is_done;
    logic is_abort;
    logic stack_empty;
    logic enough_bits;
    logic go_walk;
    logic go_write;
    logic walk_more;
    logic walk_abort;
  } stat_t;

  function automatic logic [3:0] eff_min(input logic [3:0] m);
    if (m < 4'd2) return 4'd2;
    if (m > 4'd8) return 4'd8;
    return m;
  endfunction
endpackage
`default_nettype wire

### design/glid_ram.sv
// generic single port write, single port registered read ram
`default_nettype none
module glid_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### design/glid_ctrl.sv
// controller state machine sequencing push, code fetch, chain walk and pop
`default_nettype none
module glid_ctrl import glid_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_type_i,
  output      logic  in_ready_o,
  input  wire logic  out_free_i,
  input  wire stat_t stat_i,
  output      cmd_t  cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.result = ST_TAKEN;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = out_free_i;
        if (in_valid_i && out_free_i) state_d = in_type_i ? S_CHECK : S_PUSH;
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        cmd_o.set_result = 1'b1;
        cmd_o.result = stat_i.room ? ST_TAKEN : ST_REFUSED;
        state_d = S_IDLE;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = S_FETCH;
      end
      S_FETCH: begin
        if (stat_i.is_done || stat_i.is_abort) begin
          cmd_o.set_result = 1'b1;
          cmd_o.result = stat_i.is_done ? ST_DONE : ST_ABORT;
          state_d = S_IDLE;
        end else if (!stat_i.stack_empty) begin
          cmd_o.pop_rd = 1'b1;
          state_d = S_POP;
        end else if (!stat_i.enough_bits) begin
          cmd_o.set_result = 1'b1;
          cmd_o.result = ST_NEED;
          state_d = S_IDLE;
        end else begin
          cmd_o.fetch = 1'b1;
          state_d = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        cmd_o.classify = 1'b1;
        if (stat_i.go_walk) state_d = S_WALK_RD;
        else if (stat_i.go_write) state_d = S_WRITE;
        else state_d = S_FETCH;
      end
      S_WALK_RD: begin
        cmd_o.walk_rd = 1'b1;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (stat_i.walk_abort) begin
          cmd_o.walk = 1'b1;
          state_d = S_FETCH;
        end else if (stat_i.walk_more) begin
          cmd_o.walk = 1'b1;
          state_d = S_WALK;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d = S_FETCH;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        cmd_o.set_result = 1'b1;
        cmd_o.result = ST_PIXEL;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_result |=> state_q == S_IDLE) else $error("result not final");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_RD |-> 1'b0) else $error("unused state reached");
endmodule
`default_nettype wire

### design/glid_dp.sv
// datapath: bit reservoir, code logic, dictionary and stack memories, position
`default_nettype none
module glid_dp import glid_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output      stat_t       stat_o,
  input  wire logic [7:0]  byte_i,
  input  wire logic        take_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        out_take_i,
  output      logic        out_valid_o,
  output      logic [2:0]  status_o,
  output      logic [7:0]  pixel_o,
  output      logic [15:0] pos_x_o,
  output      logic [15:0] pos_y_o
);
  logic [3:0]  min_q;
  logic [7:0]  mask_q;
  logic [15:0] width_q, height_q;
  logic        ilace_q;
  logic [7:0]  byte_q;
  logic [31:0] res_q;
  logic [5:0]  bits_q;
  logic [3:0]  cw_q;
  logic [12:0] nfc_q;
  logic [11:0] prev_q;
  logic [7:0]  last_q;
  logic        first_q, after_q;
  logic [1:0]  fin_q;
  logic [12:0] sc_q;
  logic [15:0] col_q, row_q;
  logic [1:0]  pass_q;
  logic [31:0] done_q;
  logic [11:0] code_q, cur_q;
  logic [12:0] cnt_q;
  logic        ov_q;

  logic [3:0]  em;
  logic [12:0] clr;
  logic [47:0] total;
  logic        fin_now;
  assign em = eff_min(min_q);
  assign clr = 13'd1 << em;
  assign total = {16'd0, width_q} * {16'd0, height_q};
  assign fin_now = (fin_q == 2'd0) && ({16'd0, done_q} >= total);

  logic [3:0] cw_eff;
  assign cw_eff = first_q ? em + 4'd1 : cw_q;

  // memories
  logic [11:0] pre_rd;
  logic [7:0]  suf_rd, stk_rd;
  logic        dict_we, stk_we;
  logic [11:0] dict_ra;
  logic [12:0] stk_wa, stk_ra;
  logic [7:0]  stk_wd;
  logic [7:0]  lastc;
  glid_ram #(.Width(12), .Depth(TableDepth)) u_pre (
    .clk_i, .we_i(dict_we), .waddr_i(nfc_q[11:0]), .wdata_i(prev_q),
    .raddr_i(dict_ra), .rdata_o(pre_rd));
  glid_ram #(.Width(8), .Depth(TableDepth)) u_suf (
    .clk_i, .we_i(dict_we), .waddr_i(nfc_q[11:0]), .wdata_i(lastc),
    .raddr_i(dict_ra), .rdata_o(suf_rd));
  glid_ram #(.Width(8), .Depth(StackDepth)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd));

  assign lastc = cur_q[7:0] & mask_q;
  assign dict_we = cmd_i.write;
  // read ahead along the chain while walking
  assign dict_ra = cmd_i.walk ? pre_rd : cur_q;
  assign stk_ra  = sc_q - 13'd1;
  always_comb begin
    stk_we = 1'b0;
    stk_wa = cnt_q;
    stk_wd = suf_rd;
    if (cmd_i.walk && !ov_q) stk_we = 1'b1;
    if (cmd_i.write) begin
      stk_we = 1'b1;
      stk_wd = lastc;
    end
    if (cmd_i.classify && after_q) begin
      stk_we = 1'b1;
      stk_wa = '0;
      stk_wd = code_q[7:0] & mask_q;
    end
    if (cmd_i.classify && !after_q && code_q != clr[11:0]
        && code_q != clr[11:0] + 12'd1 && nfc_q < 13'd4096
        && {1'b0, code_q} >= nfc_q) begin
      stk_we = 1'b1;
      stk_wa = '0;
      stk_wd = first_q ? (code_q[7:0] & mask_q) : last_q;
    end
  end

  // classify decisions
  logic is_clr, is_end, data_ok, kwk;
  assign is_clr = code_q == clr[11:0];
  assign is_end = code_q == clr[11:0] + 12'd1;
  assign data_ok = nfc_q < 13'd4096;
  assign kwk = {1'b0, code_q} >= nfc_q;

  always_comb begin
    stat_o.room        = bits_q <= 6'd24;
    stat_o.is_done     = fin_q == 2'd1 || fin_now;
    stat_o.is_abort    = fin_q == 2'd2;
    stat_o.stack_empty = sc_q == 13'd0;
    stat_o.enough_bits = bits_q >= {2'd0, cw_eff};
    stat_o.go_walk     = !after_q && !is_clr && !is_end && data_ok;
    stat_o.go_write    = 1'b0;
    stat_o.walk_more   = {4'd0, cur_q} > {8'd0, mask_q} && !ov_q;
    stat_o.walk_abort  = ov_q;
  end

  logic [15:0] rowa;
  logic [16:0] nr;
  logic [2:0]  stp;
  assign stp = (pass_q == 2'd3) ? 3'd2 : (pass_q == 2'd2) ? 3'd4 : 3'd0;
  assign nr = {1'b0, row_q} + ((pass_q[1]) ? {14'd0, stp} : 17'd8);
  assign rowa = row_q;

  logic [11:0] cmask;
  assign cmask = 12'hfff >> (4'd12 - cw_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 4'd8; mask_q <= 8'hff; width_q <= 16'd1; height_q <= 16'd1;
      ilace_q <= 1'b0; res_q <= '0; bits_q <= '0; cw_q <= 4'd9;
      nfc_q <= 13'd258; prev_q <= '0; last_q <= '0; first_q <= 1'b1;
      after_q <= 1'b0; fin_q <= '0; sc_q <= '0; col_q <= '0; row_q <= '0;
      pass_q <= '0; done_q <= '0; out_valid_o <= 1'b0; status_o <= '0;
      pixel_o <= '0; pos_x_o <= '0; pos_y_o <= '0; code_q <= '0; cur_q <= '0;
      cnt_q <= '0; ov_q <= 1'b0; byte_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIN:    min_q <= cfg_data_i[3:0];
          CFG_MASK:   mask_q <= cfg_data_i[7:0];
          CFG_WIDTH:  width_q <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          CFG_ILACE:  ilace_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (take_i) byte_q <= byte_i;
      if (out_take_i) out_valid_o <= 1'b0;
      if (cmd_i.push && stat_o.room) begin
        res_q <= res_q | ({24'd0, byte_q} << bits_q[4:0]);
        bits_q <= bits_q + 6'd8;
      end
      if (cmd_i.check && fin_now) fin_q <= 2'd1;
      if (cmd_i.fetch) begin
        if (first_q) begin
          cw_q <= em + 4'd1;
          nfc_q <= clr + 13'd2;
        end
        code_q <= res_q[11:0] & cmask;
        res_q <= res_q >> cw_eff;
        bits_q <= bits_q - {2'd0, cw_eff};
      end
      if (cmd_i.classify) begin
        cnt_q <= (!after_q && !is_clr && !is_end && data_ok && kwk) ? 13'd1 : 13'd0;
        ov_q <= 1'b0;
        if (after_q) begin
          after_q <= 1'b0;
          prev_q <= code_q;
          last_q <= code_q[7:0] & mask_q;
          sc_q <= 13'd1;
        end else if (is_clr) begin
          first_q <= 1'b0;
          cw_q <= em + 4'd1;
          nfc_q <= clr + 13'd2;
          after_q <= 1'b1;
        end else if (is_end) begin
          first_q <= 1'b0;
          fin_q <= 2'd1;
        end else begin
          logic [11:0] pv;
          pv = first_q ? code_q : prev_q;
          first_q <= 1'b0;
          prev_q <= pv;
          if (first_q) last_q <= code_q[7:0] & mask_q;
          if (!data_ok) fin_q <= 2'd2;
          else if (kwk) cur_q <= pv;
          else cur_q <= code_q;
        end
      end
      if (cmd_i.walk) begin
        if (ov_q) fin_q <= 2'd2;
        else begin
          cur_q <= pre_rd;
          cnt_q <= cnt_q + 13'd1;
          if (cnt_q + 13'd1 > 13'd4096) ov_q <= 1'b1;
        end
      end
      if (cmd_i.write) begin
        last_q <= lastc;
        sc_q <= cnt_q + 13'd1;
        prev_q <= code_q;
        nfc_q <= nfc_q + 13'd1;
        if ((nfc_q + 13'd1) >= (13'd1 << cw_q) && cw_q < 4'd12) cw_q <= cw_q + 4'd1;
      end
      if (cmd_i.pop) begin
        done_q <= done_q + 32'd1;
        if ({16'd0, done_q + 32'd1} >= total) begin
          fin_q <= 2'd1;
          sc_q <= '0;
        end else begin
          sc_q <= sc_q - 13'd1;
        end
        if (col_q + 16'd1 < width_q) col_q <= col_q + 16'd1;
        else begin
          col_q <= '0;
          if (!ilace_q) row_q <= row_q + 16'd1;
          else if (nr < {1'b0, height_q}) row_q <= nr[15:0];
          else if (pass_q == 2'd0 && height_q > 16'd4) begin
            pass_q <= 2'd1; row_q <= 16'd4;
          end else if (pass_q <= 2'd1 && height_q > 16'd2) begin
            pass_q <= 2'd2; row_q <= 16'd2;
          end else if (pass_q <= 2'd2 && height_q > 16'd1) begin
            pass_q <= 2'd3; row_q <= 16'd1;
          end else begin
            pass_q <= 2'd3;
            row_q <= nr[16] ? 16'hffff : nr[15:0];
          end
        end
      end
      if (cmd_i.set_result) begin
        out_valid_o <= 1'b1;
        status_o <= cmd_i.result;
        pixel_o <= (cmd_i.result == ST_PIXEL) ? stk_rd : 8'd0;
        pos_x_o <= (cmd_i.result == ST_PIXEL) ? col_q : 16'd0;
        pos_y_o <= (cmd_i.result == ST_PIXEL) ? rowa : 16'd0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= 6'd32) else $error("reservoir overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw_q <= 4'd12) else $error("code width too large");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q != 2'd3) else $error("bad finish code");
endmodule
`default_nettype wire

### design/gif_lzw_interlace_decoder_top.sv
// gif lzw raster decoder with interlaced placement, top level
// usage:
//   s_axis carries one request word: tuser is the request type (0 push a
//   raster byte, 1 pull a pixel), tdata the raster byte.
//   m_axis returns one result word per request: tdata packs status[2:0],
//   pixel index[10:3], column[26:11], row[42:27], zero filled to 48 bits.
//   configuration registers are written by cfg_we_i/cfg_idx_i/cfg_data_i;
//   the user must write them only while idle; the block does not enforce it.
// sequencing:
//   a push result is registered from the push state; a pull that pops a
//   buffered pixel passes the check, fetch and pop states. each code fetched
//   on the way passes the fetch and classify states; a data code also passes
//   the walk read, walk and write states and repeats the walk state for each
//   dictionary chain step, set by the registered read of the memories. the
//   next request is taken the cycle after the result is delivered, so no new
//   request is taken before the last result is out.
// reset clears all control state; dictionary contents are undefined until
// written. while m_axis is stalled the result is held and no new request is
// taken until it is delivered.
`default_nettype none
module gif_lzw_interlace_decoder_top import glid_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // data_byte
  input  wire logic        s_axis_tuser,  // req_type
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [47:0] m_axis_tdata,  // status, pixel_index, pos_x, pos_y
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  cmd_t  cmd;
  stat_t stat;
  logic [2:0] st;
  logic [7:0] px;
  logic [15:0] x, y;

  glid_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_type_i(s_axis_tuser),
    .in_ready_o(s_axis_tready), .out_free_i(!m_axis_tvalid),
    .stat_i(stat), .cmd_o(cmd));

  glid_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .byte_i(s_axis_tdata),
    .take_i(s_axis_tvalid && s_axis_tready), .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .out_take_i(m_axis_tvalid && m_axis_tready),
    .out_valid_o(m_axis_tvalid), .status_o(st), .pixel_o(px),
    .pos_x_o(x), .pos_y_o(y));

  assign m_axis_tdata = {5'd0, y, x, px, st};
endmodule
`default_nettype wire
